### rtl/gtk_pkg.sv
package gtk_pkg;

    localparam int MAX_GROUPS  = 64;
    localparam int GROUP_CNT_W = $clog2(MAX_GROUPS + 1);
    localparam int KEY_W       = 16;
    localparam int PRICE_W     = 32;
    localparam int QTY_W       = 16;
    localparam int AMOUNT_W    = PRICE_W + QTY_W;
    localparam int SUM_W       = 54;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [KEY_W-1:0]   shop_number;
        logic [PRICE_W-1:0] unit_price;
        logic [QTY_W-1:0]   quantity;
        logic               last_record;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] group_shop;
        logic [SUM_W-1:0] turnover;
        logic             last_group;
        logic             records_dropped;
    } t_out_item;

    // Classified record handed from the front part to the back part.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [AMOUNT_W-1:0] amount;
        logic                last;
    } t_job;

    typedef enum logic [1:0] {
        ST_MERGE = 2'b01,
        ST_EMIT  = 2'b10
    } t_back_state;

endpackage

### rtl/gtk_front.sv
module gtk_front
    import gtk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_item i_item,
    output logic     o_push,
    output t_job     o_job,
    input  logic     i_queue_ready
);

    logic r_valid;
    t_job r_job;
    logic accept;

    assign busy   = r_valid && !i_queue_ready;
    assign accept = start && !busy;
    assign o_push = r_valid && i_queue_ready;
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_queue_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Register the full-width product of price and quantity.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.key    <= i_item.shop_number;
            r_job.amount <= AMOUNT_W'(i_item.unit_price) * AMOUNT_W'(i_item.quantity);
            r_job.last   <= i_item.last_record;
        end
    end

endmodule

### rtl/gtk_queue.sv
module gtk_queue
    import gtk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### rtl/gtk_back.sv
module gtk_back
    import gtk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_result
);

    t_back_state            r_state;
    logic [GROUP_CNT_W-1:0] r_count;
    logic                   r_dropped;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [KEY_W-1:0] r_keys [MAX_GROUPS];
    logic [SUM_W-1:0] r_sums [MAX_GROUPS];

    logic [MAX_GROUPS-1:0] below;
    logic [MAX_GROUPS-1:0] hit;
    logic [SUM_W:0]        sum_add [MAX_GROUPS];
    logic                  any_hit;
    logic                  room;
    logic                  merge_en;
    logic                  emit_en;

    assign o_pop    = (r_state == ST_MERGE) && i_job_valid;
    assign merge_en = o_pop;
    assign emit_en  = (r_state == ST_EMIT) && (r_count != '0);
    assign any_hit  = |hit;
    assign room     = (r_count < GROUP_CNT_W'(MAX_GROUPS));
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Per-cell compare and add against the incoming key.
    always_comb begin
        for (int i = 0; i < MAX_GROUPS; i++) begin
            below[i]   = (GROUP_CNT_W'(i) < r_count) && (r_keys[i] < i_job.key);
            hit[i]     = (GROUP_CNT_W'(i) < r_count) && (r_keys[i] == i_job.key);
            sum_add[i] = {1'b0, r_sums[i]} + (SUM_W + 1)'(i_job.amount);
        end
    end

    for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
        logic load_here;
        logic [KEY_W-1:0] up_key;
        logic [SUM_W-1:0] up_sum;

        if (g == 0) begin : g_head
            assign load_here = 1'b1;
            assign up_key    = i_job.key;
            assign up_sum    = SUM_W'(i_job.amount);
        end else begin : g_body
            assign load_here = below[g-1];
            assign up_key    = r_keys[g-1];
            assign up_sum    = r_sums[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (merge_en) begin
                if (any_hit) begin
                    if (hit[g]) begin
                        r_sums[g] <= sum_add[g][SUM_W] ? SUM_MAX : sum_add[g][SUM_W-1:0];
                    end
                end else if (room && !below[g]) begin
                    if (load_here) begin
                        r_keys[g] <= i_job.key;
                        r_sums[g] <= SUM_W'(i_job.amount);
                    end else begin
                        r_keys[g] <= up_key;
                        r_sums[g] <= up_sum;
                    end
                end
            end else if (emit_en && (g < MAX_GROUPS - 1)) begin
                r_keys[g] <= r_keys[(g + 1) % MAX_GROUPS];
                r_sums[g] <= r_sums[(g + 1) % MAX_GROUPS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_MERGE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= emit_en;
            case (r_state)
                ST_MERGE: begin
                    if (merge_en) begin
                        if (!any_hit) begin
                            if (room) begin
                                r_count <= r_count + GROUP_CNT_W'(1);
                            end else begin
                                r_dropped <= 1'b1;
                            end
                        end
                        if (i_job.last) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (r_count <= GROUP_CNT_W'(1)) begin
                        r_state   <= ST_MERGE;
                        r_dropped <= 1'b0;
                    end
                    if (emit_en) begin
                        r_count <= r_count - GROUP_CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= ST_MERGE;
                end
            endcase
        end
    end

    // Drive the head cell onto the result register.
    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_out.group_shop      <= r_keys[0];
            r_out.turnover        <= r_sums[0];
            r_out.last_group      <= (r_count == GROUP_CNT_W'(1));
            r_out.records_dropped <= r_dropped;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= GROUP_CNT_W'(MAX_GROUPS))
        else $error("group count beyond capacity");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last_group |-> (r_count == '0) && (r_state == ST_MERGE))
        else $error("store not empty after final total");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last_group |=>
            r_out_valid && (r_out.group_shop > $past(r_out.group_shop)))
        else $error("totals not in ascending shop order");

    a_dropped_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last_group |=> $stable(r_out.records_dropped))
        else $error("dropped flag changed within a run");

endmodule

### rtl/grouped_turnover_by_key_top.sv
// After the record marked last passes the front register, queue and merge, totals
// leave one per cycle, the final one flagged; the strobe is never held off.
// Throughput: one record per cycle while the sorted cell row is merging; during
// emission of N totals the queue and front register absorb up to 5 records.
// Reset (synchronous, active low) empties the store, queue and front stage.
module grouped_turnover_by_key_top
    import gtk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    // Front stage: take the transaction and form price times quantity.
    logic q_push;
    logic q_ready;
    t_job front_job;

    gtk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_push        (q_push),
        .o_job         (front_job),
        .i_queue_ready (q_ready)
    );

    // Queue: hold classified records while the back end emits totals.
    logic q_valid;
    logic q_pop;
    t_job back_job;

    gtk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    // Back end: merge into the sorted cell row, then shift totals out in order.
    gtk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (back_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import gtk_pkg::*;

    // Cycle budget for the whole run; the slowest legal run stays far below it.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to watch for stray totals once nothing is expected any more.
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_CAP = 10;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_valid;
    t_out_item o_result;

    grouped_turnover_by_key_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the block's sorted shop store.
    logic [KEY_W-1:0] ledger_keys [MAX_GROUPS];
    logic [SUM_W-1:0] ledger_sums [MAX_GROUPS];
    int               ledger_count   = 0;
    logic             ledger_dropped = 1'b0;

    // Totals expected on the result side, oldest first.
    t_out_item pending_totals [$];

    int fail_count   = 0;
    int records_sent = 0;
    int idle_pct     = 13;
    int cycles       = 0;

    task automatic note_failure(input string what);
        if (fail_count < REPORT_CAP) begin
            $display("[%0t] %s", $realtime, what);
        end
        fail_count++;
    endtask

    // Merge one accepted record into the shadow store; on a last record,
    // queue one total per shop in ascending order and clear the store.
    task automatic book_record(input t_in_item rec);
        logic [AMOUNT_W-1:0] amount;
        logic [SUM_W:0]      wide;
        int                  pos;
        int                  k;
        t_out_item           total;
        amount = AMOUNT_W'(rec.unit_price) * AMOUNT_W'(rec.quantity);
        pos = 0;
        while (pos < ledger_count && ledger_keys[pos] < rec.shop_number) begin
            pos++;
        end
        if (pos < ledger_count && ledger_keys[pos] == rec.shop_number) begin
            // Saturate rather than wrap at the top of the sum range.
            wide = {1'b0, ledger_sums[pos]} + (SUM_W+1)'(amount);
            ledger_sums[pos] = (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_W-1:0];
        end else if (ledger_count >= MAX_GROUPS) begin
            ledger_dropped = 1'b1;
        end else begin
            for (k = ledger_count; k > pos; k--) begin
                ledger_keys[k] = ledger_keys[k-1];
                ledger_sums[k] = ledger_sums[k-1];
            end
            ledger_keys[pos] = rec.shop_number;
            ledger_sums[pos] = SUM_W'(amount);
            ledger_count++;
        end
        if (rec.last_record) begin
            for (k = 0; k < ledger_count; k++) begin
                total.group_shop      = ledger_keys[k];
                total.turnover        = ledger_sums[k];
                total.last_group      = (k + 1 == ledger_count);
                total.records_dropped = ledger_dropped;
                pending_totals.push_back(total);
            end
            ledger_count   = 0;
            ledger_dropped = 1'b0;
        end
    endtask

    // Present one record and hold it until the block takes it. Start is only
    // lowered during an idle gap, so it never toggles twice in one time step.
    task automatic send_record(input logic [KEY_W-1:0]   shop,
                               input logic [PRICE_W-1:0] price,
                               input logic [QTY_W-1:0]   qty,
                               input logic               last);
        t_in_item rec;
        rec.shop_number = shop;
        rec.unit_price  = price;
        rec.quantity    = qty;
        rec.last_record = last;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= rec;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        book_record(rec);
        records_sent++;
    endtask

    // Pause the sender until every expected total has come out.
    task automatic wait_for_totals();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_totals.size() != 0);
    endtask

    function automatic logic [PRICE_W-1:0] pick_price();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return PRICE_W'($urandom_range(255));
            default: return PRICE_W'($urandom);
        endcase
    endfunction

    function automatic logic [QTY_W-1:0] pick_qty();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return QTY_W'($urandom_range(15));
            default: return QTY_W'($urandom);
        endcase
    endfunction

    // One-record tables at both ends of every field.
    task automatic test_single_records();
        send_record('0, '0, '0, 1'b1);
        send_record('1, '1, '1, 1'b1);
        send_record(16'h8000, 32'h0000_0001, 16'h0001, 1'b1);
        wait_for_totals();
    endtask

    // Shops out of order, a repeated shop, zero price and zero quantity.
    task automatic test_mixed_table();
        send_record(16'd500,   32'd1000,     16'd3,     1'b0);
        send_record(16'd20,    32'd7,        16'd9,     1'b0);
        send_record(16'hFFFF,  '0,           16'd44,    1'b0);
        send_record(16'd20,    32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_record(16'd0,     32'd12345,    '0,        1'b0);
        send_record(16'd300,   32'h5555_AAAA, 16'hAA55, 1'b1);
        wait_for_totals();
    endtask

    // Each new shop lands ahead of everything held.
    task automatic test_descending_keys();
        int k;
        for (k = 9; k >= 3; k--) begin
            send_record(KEY_W'(k), PRICE_W'(k * 11), QTY_W'(k), k == 3);
        end
        wait_for_totals();
    endtask

    // Short tables with random content; keys from a narrow or a wide pool.
    task automatic test_random_tables(input int budget);
        int               stop_at;
        int               len;
        int               j;
        bit               narrow;
        logic [KEY_W-1:0] shop;
        stop_at = records_sent + budget;
        while (records_sent < stop_at) begin
            len    = $urandom_range(1, 12);
            narrow = 1'($urandom_range(1));
            for (j = 0; j < len; j++) begin
                shop = narrow ? KEY_W'($urandom_range(15)) : KEY_W'($urandom);
                send_record(shop, pick_price(), pick_qty(), j == len - 1);
            end
            // Drain now and then so idle restarts hit every phase.
            if ($urandom_range(3) == 0) begin
                wait_for_totals();
            end
        end
        wait_for_totals();
    endtask

    // Exactly MAX_GROUPS distinct shops: the store fills with no drop.
    task automatic test_full_store();
        int               k;
        logic [KEY_W-1:0] offset;
        offset = KEY_W'($urandom);
        for (k = 0; k < MAX_GROUPS; k++) begin
            send_record(KEY_W'(k * 997) + offset, pick_price(), pick_qty(),
                        k == MAX_GROUPS - 1);
        end
        wait_for_totals();
    endtask

    // Past a full store new shops are dropped while held shops still merge.
    task automatic test_store_overflow();
        int               k;
        int               extra;
        logic [KEY_W-1:0] offset;
        offset = KEY_W'($urandom);
        for (k = 0; k < MAX_GROUPS; k++) begin
            send_record(KEY_W'(k * 997) + offset, pick_price(), pick_qty(), 1'b0);
        end
        for (extra = 0; extra < 16; extra++) begin
            if (extra[0]) begin
                k = $urandom_range(MAX_GROUPS - 1);
            end else begin
                k = MAX_GROUPS + extra;
            end
            send_record(KEY_W'(k * 997) + offset, pick_price(), pick_qty(), extra == 15);
        end
        wait_for_totals();
    endtask

    // Enough full-size amounts on one shop to push its total into saturation.
    task automatic test_turnover_saturation();
        int               k;
        logic [KEY_W-1:0] shop;
        shop = KEY_W'($urandom);
        for (k = 0; k < 70; k++) begin
            if (k % 20 == 7) begin
                send_record(shop ^ 16'h0101, pick_price(), pick_qty(), 1'b0);
            end else begin
                send_record(shop, '1, '1, k == 69);
            end
        end
        wait_for_totals();
    endtask

    // Compare each total with the oldest expectation, field by field.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_totals.size() == 0) begin
                note_failure($sformatf("unexpected total shop=%h turnover=%h",
                                       o_result.group_shop, o_result.turnover));
            end else begin
                want = pending_totals.pop_front();
                if (o_result.group_shop      !== want.group_shop ||
                    o_result.turnover        !== want.turnover ||
                    o_result.last_group      !== want.last_group ||
                    o_result.records_dropped !== want.records_dropped) begin
                    note_failure($sformatf(
                        "mismatch exp %h/%h/%b/%b got %h/%h/%b/%b",
                        want.group_shop, want.turnover, want.last_group,
                        want.records_dropped, o_result.group_shop, o_result.turnover,
                        o_result.last_group, o_result.records_dropped));
                end
            end
        end
    end

    // Watchdog: give up if the run outlasts the cycle budget.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        // Hold reset, then release it on a clock edge.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_records();
        test_mixed_table();
        test_descending_keys();
        test_random_tables(70);

        // Long stretch with a sender that never pauses.
        idle_pct = 0;
        test_full_store();
        test_store_overflow();
        test_turnover_saturation();
        idle_pct = 13;

        test_random_tables(65);

        // Watch for stray totals, then flag anything still outstanding.
        wait_for_totals();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_totals.size() != 0) begin
            note_failure($sformatf("%0d totals never arrived", pending_totals.size()));
        end

        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
